// ===== rtl/rlf_pkg.sv =====
// Shared types, constants and helpers for the RGB linear fade engine.
// No dependencies; every other file uses this package.
package rlf_pkg;

  localparam int LEVEL_W = 8;
  localparam int REQ_W   = 11;
  localparam int DUR_W   = 16;
  localparam int CMD_W   = 2;
  localparam int QUOT_W  = LEVEL_W;
  localparam int FIELD_CHANNELS = 3;

  typedef logic [LEVEL_W-1:0] level_t;
  typedef logic signed [REQ_W-1:0] req_level_t;

  // Command codes carried in the cmd field.
  typedef enum logic [CMD_W-1:0] {
    CMD_SET  = 2'd0,
    CMD_FADE = 2'd1,
    CMD_TICK = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // Clamp a signed request to the legal drive range.
  function automatic level_t clamp_level(input req_level_t v);
    level_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > req_level_t'(255)) begin
      r = '1;
    end else begin
      r = v[LEVEL_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/rlf_if.sv =====
// Handshake channels for the RGB linear fade engine: commands in, levels out.
// Depends on rlf_pkg for field widths.
interface rlf_req_if;
  logic                                valid;
  logic                                ready;
  logic [rlf_pkg::CMD_W-1:0]           cmd;
  logic signed [rlf_pkg::REQ_W-1:0]    red_in;
  logic signed [rlf_pkg::REQ_W-1:0]    green_in;
  logic signed [rlf_pkg::REQ_W-1:0]    blue_in;
  logic [rlf_pkg::DUR_W-1:0]           duration_ms;

  modport source(output valid, cmd, red_in, green_in, blue_in, duration_ms, input ready);
  modport sink(input valid, cmd, red_in, green_in, blue_in, duration_ms, output ready);
endinterface

interface rlf_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [rlf_pkg::LEVEL_W-1:0]   red_level;
  logic [rlf_pkg::LEVEL_W-1:0]   green_level;
  logic [rlf_pkg::LEVEL_W-1:0]   blue_level;
  logic                          updated;
  logic                          fading;

  modport source(output valid, red_level, green_level, blue_level, updated, fading,
                 input ready);
  modport sink(input valid, red_level, green_level, blue_level, updated, fading,
               output ready);
endinterface

// ===== rtl/rgb_linear_fade.sv =====
// Top level of the RGB linear fade engine: command decode, level state, sequencer.
// Depends on rlf_pkg, the rlf_req_if / rlf_rsp_if channels and rlf_interp.
//
//  Channel  Dir  Handshake      Payload
//  req      in   valid/ready    cmd, red_in, green_in, blue_in, duration_ms
//  rsp      out  valid/ready    red_level, green_level, blue_level, updated, fading
//
// Set, fade, idle tick and the final tick of a fade go from S_IDLE through S_OUT to a result.
// An interior fade tick passes through S_CALC before S_OUT:
// each channel runs through the shared interpolation unit (multiply, 8 divide steps).
// A result held in the output register does not block the next command.
// Synchronous reset clears all levels, the fade state and the response valid.
module rgb_linear_fade #(
  parameter int CHANNELS  = 3,
  parameter int TIME_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  rlf_req_if.sink   req,
  rlf_rsp_if.source rsp
);
  import rlf_pkg::*;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int N_SHOW = (CHANNELS < FIELD_CHANNELS) ? CHANNELS : FIELD_CHANNELS;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CALC = 4'b0010,
    S_OUT  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t               state;
  level_t               current [CHANNELS];
  level_t               start_lv [CHANNELS];
  level_t               target [CHANNELS];
  logic                 fade_active;
  logic [TIME_BITS-1:0] elapsed;
  logic [TIME_BITS-1:0] fade_length;
  logic                 upd;
  logic [CH_W-1:0]      ch;
  logic                 wait_div;

  logic                 accept;
  level_t               req_lvl [CHANNELS];
  req_level_t           raw [FIELD_CHANNELS];
  logic [TIME_BITS-1:0] elapsed_next;
  logic                 div_start;
  logic                 div_done;
  level_t               div_level;
  level_t               show [FIELD_CHANNELS];
  logic                 out_free;

  assign accept    = req.valid && req.ready;
  assign req.ready = state == S_IDLE;
  assign out_free  = !rsp.valid || rsp.ready;
  assign div_start = (state == S_CALC) && !wait_div;

  // Clamped requests; channels past the third ask for zero.
  always_comb begin
    raw[0] = req.red_in;
    raw[1] = req.green_in;
    raw[2] = req.blue_in;
    for (int i = 0; i < CHANNELS; i++) begin
      req_lvl[i] = '0;
    end
    for (int i = 0; i < N_SHOW; i++) begin
      req_lvl[i] = clamp_level(raw[i]);
    end
  end

  // Saturating millisecond count.
  assign elapsed_next = (elapsed == '1) ? elapsed : elapsed + 1'b1;

  // Levels of absent channels read as zero.
  always_comb begin
    for (int i = 0; i < FIELD_CHANNELS; i++) begin
      show[i] = '0;
    end
    for (int i = 0; i < N_SHOW; i++) begin
      show[i] = current[i];
    end
  end

  rlf_interp #(
    .TIME_BITS(TIME_BITS)
  ) u_interp (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .elapsed   (elapsed),
    .length    (fade_length),
    .start_lvl (start_lv[ch]),
    .target_lvl(target[ch]),
    .done      (div_done),
    .level     (div_level)
  );

  // Command sequencer and level state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      fade_active <= 1'b0;
      elapsed     <= '0;
      fade_length <= '0;
      upd         <= 1'b0;
      ch          <= '0;
      wait_div    <= 1'b0;
      for (int i = 0; i < CHANNELS; i++) begin
        current[i]  <= '0;
        start_lv[i] <= '0;
        target[i]   <= '0;
      end
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            upd   <= 1'b0;
            state <= S_OUT;
            case (req.cmd)
              CMD_SET: begin
                for (int i = 0; i < CHANNELS; i++) begin
                  current[i] <= req_lvl[i];
                end
                fade_active <= 1'b0;
                upd         <= 1'b1;
              end
              CMD_FADE: begin
                fade_length <= TIME_BITS'(req.duration_ms);
                for (int i = 0; i < CHANNELS; i++) begin
                  target[i]   <= req_lvl[i];
                  start_lv[i] <= current[i];
                end
                elapsed     <= '0;
                fade_active <= 1'b1;
              end
              CMD_TICK: begin
                if (fade_active) begin
                  elapsed <= elapsed_next;
                  if (elapsed_next >= fade_length) begin
                    // Final step: snap to the targets and report it.
                    for (int i = 0; i < CHANNELS; i++) begin
                      current[i] <= target[i];
                    end
                    fade_active <= 1'b0;
                    upd         <= 1'b1;
                  end else begin
                    ch       <= '0;
                    wait_div <= 1'b0;
                    state    <= S_CALC;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CALC: begin
          // One channel at a time through the shared unit.
          if (div_start) begin
            wait_div <= 1'b1;
          end
          if (div_done) begin
            wait_div <= 1'b0;
            if (div_level != current[ch]) begin
              current[ch] <= div_level;
              upd         <= 1'b1;
            end
            if (ch == CH_W'(CHANNELS-1)) begin
              state <= S_OUT;
            end else begin
              ch <= ch + 1'b1;
            end
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: loaded when the result is ready and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      rsp.red_level   <= show[0];
      rsp.green_level <= show[1];
      rsp.blue_level  <= show[2];
      rsp.updated     <= upd;
      rsp.fading      <= fade_active;
    end
  end

  // Interpolation only runs while a fade is in progress.
  a_calc_fading: assert property (@(posedge clk) disable iff (rst)
    state == S_CALC |-> fade_active) else $error("interpolating without a fade");

  // A set transaction always leads straight to a result.
  a_set_out: assert property (@(posedge clk) disable iff (rst)
    accept && req.cmd == CMD_SET |=> state == S_OUT && upd && !fade_active)
    else $error("set transaction mishandled");

  // Interpolation results arrive only while the sequencer waits for them.
  a_done_calc: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_CALC && wait_div) else $error("stray interp result");

  // Elapsed time stays below the length during an interior step.
  a_calc_elapsed: assert property (@(posedge clk) disable iff (rst)
    state == S_CALC |-> elapsed < fade_length) else $error("interior step past end");

endmodule

// ===== rtl/rlf_interp.sv =====
// Interpolation unit: level = start + elapsed * (target - start) / length.
// One multiply step, then an eight-step restoring divide. Uses rlf_pkg.
module rlf_interp #(
  parameter int TIME_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [TIME_BITS-1:0]   elapsed,
  input  logic [TIME_BITS-1:0]   length,
  input  rlf_pkg::level_t        start_lvl,
  input  rlf_pkg::level_t        target_lvl,
  output logic                   done,
  output rlf_pkg::level_t        level
);
  import rlf_pkg::*;

  localparam int PROD_W = TIME_BITS + LEVEL_W;
  localparam int STEP_W = $clog2(QUOT_W);

  typedef enum logic [2:0] {
    D_IDLE = 3'b001,
    D_MUL  = 3'b010,
    D_DIV  = 3'b100
  } dstate_t;

  dstate_t              state;
  logic [TIME_BITS-1:0] mul_a;
  level_t               mag;
  logic                 neg;
  level_t               base;
  logic [PROD_W-1:0]    rem;
  logic [PROD_W-1:0]    den;
  level_t               quot;
  logic [STEP_W-1:0]    step;
  logic [PROD_W-1:0]    rem_diff;
  logic                 fits;

  // Shared compare and subtract of the divide step.
  assign rem_diff = rem - den;
  assign fits     = rem >= den;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        D_IDLE: begin
          // Latch operands; the divisor is aligned to the top quotient bit.
          if (start) begin
            mul_a <= elapsed;
            neg   <= target_lvl < start_lvl;
            mag   <= (target_lvl < start_lvl) ? start_lvl - target_lvl
                                              : target_lvl - start_lvl;
            base  <= start_lvl;
            den   <= {1'b0, length, {(LEVEL_W-1){1'b0}}};
            state <= D_MUL;
          end
        end
        D_MUL: begin
          // Magnitude product; the quotient is below 256 since elapsed < length.
          rem   <= PROD_W'(mul_a * mag);
          quot  <= '0;
          step  <= '0;
          state <= D_DIV;
        end
        D_DIV: begin
          if (fits) begin
            rem <= rem_diff;
          end
          quot <= {quot[QUOT_W-2:0], fits};
          den  <= den >> 1;
          step <= step + 1'b1;
          if (step == STEP_W'(QUOT_W-1)) begin
            // Truncation toward zero: apply the sign to the magnitude quotient.
            level <= neg ? base - {quot[QUOT_W-2:0], fits}
                         : base + {quot[QUOT_W-2:0], fits};
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: begin
          state <= D_IDLE;
        end
      endcase
    end
  end

  // A start is only issued while the unit is idle.
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    start |-> state == D_IDLE) else $error("interp start while busy");

  // A start is followed by done once the multiply and all eight divide steps have run.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##10 done) else $error("interp latency wrong");

  // The divide never sees a zero divisor.
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == D_MUL |-> den != '0) else $error("interp zero divisor");

endmodule

// ===== test/rlf_level_checker.sv =====
`timescale 1ns / 100ps
// Checker for the RGB linear fade engine: predicts the level result of every
// accepted command and compares it with the response stream.
// Depends on rlf_pkg and the rlf_req_if / rlf_rsp_if channels.
module rlf_level_checker (
  input  logic  clk,
  input  logic  rst,
  rlf_req_if    req,
  rlf_rsp_if    rsp,
  output int    mismatches,
  output int    pending
);
  import rlf_pkg::*;

  typedef struct packed {
    level_t red;
    level_t green;
    level_t blue;
    logic   updated;
    logic   fading;
  } levels_t;

  // Predicted engine state.
  level_t               lvl_now  [FIELD_CHANNELS];
  level_t               lvl_from [FIELD_CHANNELS];
  level_t               lvl_to   [FIELD_CHANNELS];
  logic                 in_fade;
  logic [DUR_W-1:0]     ms_done;
  logic [DUR_W-1:0]     ms_total;

  levels_t expected_levels[$];
  int      error_cnt = 0;

  // Saturate a signed request into the 0..255 drive range.
  function automatic level_t saturate_request(input logic signed [REQ_W-1:0] v);
    int x;
    x = v;
    if (x < 0) x = 0;
    if (x > 255) x = 255;
    return level_t'(x);
  endfunction

  // Apply one command to the predicted state and return the resulting levels.
  function automatic levels_t predict_levels(input cmd_t op,
                                             input logic signed [REQ_W-1:0] r,
                                             input logic signed [REQ_W-1:0] g,
                                             input logic signed [REQ_W-1:0] b,
                                             input logic [DUR_W-1:0] dur);
    levels_t res;
    level_t  asked [FIELD_CHANNELS];
    longint  span;
    longint  step;
    longint  nv;
    longint  done_l;
    longint  total_l;
    logic    changed;
    int      i;
    asked[0] = saturate_request(r);
    asked[1] = saturate_request(g);
    asked[2] = saturate_request(b);
    changed = 1'b0;
    case (op)
      CMD_SET: begin
        for (i = 0; i < FIELD_CHANNELS; i++) lvl_now[i] = asked[i];
        in_fade = 1'b0;
        changed = 1'b1;
      end
      CMD_FADE: begin
        ms_total = dur;
        for (i = 0; i < FIELD_CHANNELS; i++) begin
          lvl_to[i]   = asked[i];
          lvl_from[i] = lvl_now[i];
        end
        ms_done = '0;
        in_fade = 1'b1;
      end
      CMD_TICK: begin
        if (in_fade) begin
          if (ms_done != '1) ms_done = ms_done + 1'b1;
          if (ms_done >= ms_total) begin
            // Final step: land exactly on the targets and always report it.
            for (i = 0; i < FIELD_CHANNELS; i++) lvl_now[i] = lvl_to[i];
            in_fade = 1'b0;
            changed = 1'b1;
          end else begin
            // Interior step: signed interpolation, quotient truncated toward zero.
            done_l  = ms_done;
            total_l = ms_total;
            for (i = 0; i < FIELD_CHANNELS; i++) begin
              span = lvl_to[i];
              span = span - longint'(lvl_from[i]);
              step = (done_l * span) / total_l;
              nv   = step + longint'(lvl_from[i]);
              if (nv < 0) nv = 0;
              if (nv > 255) nv = 255;
              if (level_t'(nv) != lvl_now[i]) begin
                lvl_now[i] = level_t'(nv);
                changed = 1'b1;
              end
            end
          end
        end
      end
      default: ;
    endcase
    res.red     = lvl_now[0];
    res.green   = lvl_now[1];
    res.blue    = lvl_now[2];
    res.updated = changed;
    res.fading  = in_fade;
    return res;
  endfunction

  // Predict on every request transaction, then check every response transaction.
  // The request is handled first so that a same-edge pair can never look unexpected.
  always @(posedge clk) begin
    levels_t seen;
    levels_t want;
    int i;
    if (rst) begin
      for (i = 0; i < FIELD_CHANNELS; i++) begin
        lvl_now[i]  = '0;
        lvl_from[i] = '0;
        lvl_to[i]   = '0;
      end
      in_fade  = 1'b0;
      ms_done  = '0;
      ms_total = '0;
      expected_levels.delete();
    end else begin
      if (req.valid && req.ready) begin
        expected_levels.push_back(predict_levels(cmd_t'(req.cmd), req.red_in, req.green_in,
                                                 req.blue_in, req.duration_ms));
      end
      if (rsp.valid && rsp.ready) begin
        seen.red     = rsp.red_level;
        seen.green   = rsp.green_level;
        seen.blue    = rsp.blue_level;
        seen.updated = rsp.updated;
        seen.fading  = rsp.fading;
        if (expected_levels.size() == 0) begin
          error_cnt++;
          if (error_cnt <= 10) begin
            $display("[%0t] unexpected response: r=%0d g=%0d b=%0d upd=%0b fad=%0b",
                     $realtime, seen.red, seen.green, seen.blue, seen.updated, seen.fading);
          end
        end else begin
          want = expected_levels.pop_front();
          if (seen !== want) begin
            error_cnt++;
            if (error_cnt <= 10) begin
              $display("[%0t] mismatch: expected r=%0d g=%0d b=%0d upd=%0b fad=%0b",
                       $realtime, want.red, want.green, want.blue, want.updated,
                       want.fading);
              $display("            actual   r=%0d g=%0d b=%0d upd=%0b fad=%0b",
                       seen.red, seen.green, seen.blue, seen.updated, seen.fading);
            end
          end
        end
      end
    end
    mismatches <= error_cnt;
    pending    <= expected_levels.size();
  end

endmodule

// ===== test/tb_rgb_linear_fade.sv =====
`timescale 1ns / 100ps
// Testbench top for the RGB linear fade engine: clock, reset, command stimulus,
// response back-pressure and the verdict. Depends on rlf_pkg, the channel
// interfaces, rgb_linear_fade and rlf_level_checker.
module tb_rgb_linear_fade;
  import rlf_pkg::*;

  localparam int RANDOM_ITEMS = 1000;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   pending;
  int   cycles = 0;
  int   stall_left = 0;
  logic steady = 1'b0;

  rlf_req_if req ();
  rlf_rsp_if rsp ();

  rgb_linear_fade dut (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  rlf_level_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .mismatches (mismatches),
    .pending    (pending)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Fade lengths: mostly short so fades complete, a few long ones.
  function automatic int pick_duration();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 12);
    if (r < 90) return $urandom_range(13, 100);
    if (r < 98) return $urandom_range(101, 400);
    return $urandom_range(401, 65535);
  endfunction

  // Requested level: mostly in range, otherwise anywhere in the 11-bit field.
  function automatic logic [REQ_W-1:0] rand_request();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) return REQ_W'($urandom_range(0, 255));
    if (r == 6) return REQ_W'($urandom_range(0, 1) ? 255 : 0);
    return REQ_W'($urandom_range(0, 2047));
  endfunction

  // Response back-pressure.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      rsp.ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!steady && $urandom_range(0, 99) < 25) begin
      rsp.ready  <= 1'b0;
      stall_left <= pick_gap();
    end else begin
      rsp.ready <= 1'b1;
    end
  end

  // Drive one command transaction and hold it until accepted.
  task automatic send_item(input cmd_t op, input logic [REQ_W-1:0] r,
                           input logic [REQ_W-1:0] g, input logic [REQ_W-1:0] b,
                           input logic [DUR_W-1:0] dur);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.cmd         <= op;
    req.red_in      <= r;
    req.green_in    <= g;
    req.blue_in     <= b;
    req.duration_ms <= dur;
    do @(posedge clk); while (!req.ready);
  endtask

  // A tick carries don't-care levels and length, randomized to exercise every bit.
  task automatic send_tick();
    send_item(CMD_TICK, REQ_W'($urandom_range(0, 2047)), REQ_W'($urandom_range(0, 2047)),
              REQ_W'($urandom_range(0, 2047)), DUR_W'($urandom_range(0, 65535)));
  endtask

  initial begin
    int   counted;
    int   seq_kind;
    int   dur;
    int   n_ticks;
    cmd_t op;
    req.valid       <= 1'b0;
    req.cmd         <= CMD_NONE;
    req.red_in      <= '0;
    req.green_in    <= '0;
    req.blue_in     <= '0;
    req.duration_ms <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: clamping extremes, unused code and a tick while idle.
    send_item(CMD_SET, 11'sd1023, -11'sd1024, 11'sd255, 16'd0);
    send_item(CMD_SET, 11'sd256, -11'sd1, 11'sd0, 16'hFFFF);
    send_item(CMD_SET, 11'sd0, 11'sd0, 11'sd0, 16'h5A5A);
    send_item(CMD_NONE, 11'sd100, 11'sd100, 11'sd100, 16'd7);
    send_tick();
    // Short fade: interior steps and the final step.
    send_item(CMD_FADE, 11'sd200, 11'sd100, 11'sd50, 16'd4);
    repeat (4) send_tick();
    send_tick();
    // Zero-length fade finishes on the first tick.
    send_item(CMD_FADE, 11'sd0, 11'sd300, -11'sd5, 16'd0);
    send_tick();
    // Fade onto the current levels: no interior change, final step still reported.
    send_item(CMD_FADE, 11'sd0, 11'sd255, 11'sd0, 16'd2);
    repeat (2) send_tick();
    // Longest fade, then cancelled by a set.
    send_item(CMD_FADE, 11'sd255, 11'sd255, 11'sd255, 16'hFFFF);
    repeat (2) send_tick();
    send_item(CMD_SET, 11'sd10, 11'sd20, 11'sd30, 16'd3);
    send_tick();
    // Fade restarted from mid-fade levels, falling and rising channels.
    send_item(CMD_FADE, 11'sd250, 11'sd0, 11'sd128, 16'd3);
    send_tick();
    send_item(CMD_FADE, 11'sd5, 11'sd5, 11'sd5, 16'd2);
    repeat (2) send_tick();

    // Random part: mostly complete fades with random content, plus sets and noise.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      steady   = ($urandom_range(0, 9) == 0);
      seq_kind = $urandom_range(0, 99);
      if (seq_kind < 60) begin
        if ($urandom_range(0, 2) == 0) begin
          send_item(CMD_SET, rand_request(), rand_request(), rand_request(),
                    DUR_W'($urandom_range(0, 65535)));
          counted++;
        end
        dur = pick_duration();
        send_item(CMD_FADE, rand_request(), rand_request(), rand_request(), DUR_W'(dur));
        if (dur > 400) n_ticks = $urandom_range(0, 5);
        else n_ticks = dur + $urandom_range(0, 2);
        // Some fades are broken off early by the next command.
        if ($urandom_range(0, 6) == 0) n_ticks = $urandom_range(0, n_ticks);
        repeat (n_ticks) send_tick();
        counted += 1 + n_ticks;
      end else if (seq_kind < 80) begin
        send_item(CMD_SET, rand_request(), rand_request(), rand_request(),
                  DUR_W'($urandom_range(0, 65535)));
        counted++;
      end else if (seq_kind < 95) begin
        op = cmd_t'($urandom_range(0, 3));
        send_item(op, REQ_W'($urandom_range(0, 2047)), REQ_W'($urandom_range(0, 2047)),
                  REQ_W'($urandom_range(0, 2047)), DUR_W'($urandom_range(0, 65535)));
        if (op == CMD_SET || op == CMD_FADE) counted++;
      end else begin
        repeat ($urandom_range(1, 3)) send_tick();
      end
    end
    steady = 1'b0;
    req.valid <= 1'b0;

    // Let the last transaction reach the checker, drain outstanding responses,
    // then keep watching for stray ones.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
